@@ src/iapr_pkg.sv @@
// Shared types, constants and helper functions for the intra average pixel reconstructor.
// No dependencies; every other file of the block but iapr_row_mem depends on this package.
package iapr_pkg;

    localparam int CFG_DATA_W        = 13;
    localparam int CFG_INDEX_W       = 1;
    localparam int RESIDUAL_W        = 9;
    localparam int PIXEL_W           = 8;
    localparam int ROW_W             = 12;
    localparam int HEIGHT_W          = ROW_W + 1;
    localparam int MAX_HEIGHT        = 4096;
    localparam int MAX_WIDTH_DEFAULT = 4096;
    localparam int WIDTH_RESET       = 640;
    localparam int HEIGHT_RESET      = 480;
    localparam int SUM_W             = 10;
    localparam int RECIP_SHIFT       = 11;
    localparam int RECIP             = 683;
    localparam int PROD_W            = SUM_W + RECIP_SHIFT;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic first_row;
        logic first_col;
        logic last_col;
        logic last_row;
    } pos_t;

    function automatic logic [31:0] clamp_size(input logic [31:0] v, input logic [31:0] limit);
        logic [31:0] r;
        if (v == 32'd0)
        begin
            r = 32'd1;
        end
        else if (v > limit)
        begin
            r = limit;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [PIXEL_W-1:0] div3(input logic [SUM_W-1:0] x);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(x) * PROD_W'(RECIP);
        return prod[RECIP_SHIFT +: PIXEL_W];
    endfunction

endpackage

@@ src/intra_average_pixel_reconstruct.sv @@
// Top level of the intra average pixel reconstructor; wires position, predictor and line store.
// Depends on iapr_pkg, iapr_position, iapr_predict and iapr_row_mem.
//
// Takes one signed residual per request in raster order and returns one reconstructed
// 8-bit pixel per request, plus a flag on the last pixel of each frame. Throughput is one
// pixel per clock while out_stall is low; each request is registered in the input stage and
// its result in the output register. The cycle is set by the left-pixel feedback: three-term
// add, divide by three and residual add run combinationally between those registers. The
// line store is a MAX_WIDTH x 8 memory with one write and one registered read port; it needs
// no clearing after reset. Frame sizes are written through cfg; the user must do so only while
// idle (not enforced by the block); a size of zero acts as one, above the limit it is clamped.
module intra_average_pixel_reconstruct #(
    parameter int MAX_WIDTH = iapr_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [iapr_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [iapr_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [iapr_pkg::RESIDUAL_W-1:0] residual,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [iapr_pkg::PIXEL_W-1:0]           pixel,
    output logic                                   frame_end
);
    import iapr_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic               accept;
    logic [COL_W-1:0]   col;
    pos_t               pos;
    logic               mem_we;
    logic [COL_W-1:0]   mem_waddr;
    logic [PIXEL_W-1:0] mem_wdata;
    logic [PIXEL_W-1:0] mem_rdata;

    iapr_position #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_position (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (accept),
        .col       (col),
        .pos       (pos)
    );

    iapr_row_mem #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W),
        .DATA_W (PIXEL_W)
    ) u_row_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (accept),
        .raddr (col),
        .rdata (mem_rdata)
    );

    iapr_predict #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_predict (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .residual  (residual),
        .col       (col),
        .pos       (pos),
        .accept    (accept),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel     (pixel),
        .frame_end (frame_end)
    );

endmodule

@@ src/iapr_row_mem.sv @@
// Line store holding the previous row of reconstructed pixels.
// One write port and one registered read port; depends on nothing else.
module iapr_row_mem #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/iapr_position.sv @@
// Frame size registers and raster position counters.
// Depends on iapr_pkg for the size constants, the register codes and pos_t.
module iapr_position #(
    parameter int MAX_WIDTH = iapr_pkg::MAX_WIDTH_DEFAULT,
    parameter int COL_W     = $clog2(MAX_WIDTH)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [iapr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [iapr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             advance,
    output logic [COL_W-1:0]                 col,
    output iapr_pkg::pos_t                   pos
);
    import iapr_pkg::*;

    localparam int WIDTH_W = COL_W + 1;

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [COL_W-1:0]    col_reg;
    logic [COL_W-1:0]    col_next;
    logic [ROW_W-1:0]    row_reg;
    logic [ROW_W-1:0]    row_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_W'(clamp_size(32'(WIDTH_RESET), 32'(MAX_WIDTH)));
            height_reg <= HEIGHT_W'(clamp_size(32'(HEIGHT_RESET), 32'(MAX_HEIGHT)));
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:
                begin
                    width_reg <= WIDTH_W'(clamp_size(32'(cfg_data), 32'(MAX_WIDTH)));
                end
                REG_FRAME_HEIGHT:
                begin
                    height_reg <= HEIGHT_W'(clamp_size(32'(cfg_data), 32'(MAX_HEIGHT)));
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        pos.first_row = (row_reg == '0);
        pos.first_col = (col_reg == '0);
        pos.last_col  = ((WIDTH_W'(col_reg) + WIDTH_W'(1)) >= width_reg);
        pos.last_row  = ((HEIGHT_W'(row_reg) + HEIGHT_W'(1)) >= height_reg);
        col_next      = col_reg;
        row_next      = row_reg;
        if (advance)
        begin
            if (pos.last_col)
            begin
                col_next = '0;
                row_next = pos.last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign col = col_reg;

endmodule

@@ src/iapr_predict.sv @@
// Request handshake, predictor and result register of the reconstructor.
// Depends on iapr_pkg for pos_t, widths and the divide-by-3 function.
module iapr_predict #(
    parameter int MAX_WIDTH = iapr_pkg::MAX_WIDTH_DEFAULT,
    parameter int COL_W     = $clog2(MAX_WIDTH)
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [iapr_pkg::RESIDUAL_W-1:0] residual,
    input  logic [COL_W-1:0]                       col,
    input  iapr_pkg::pos_t                         pos,
    output logic                                   accept,
    output logic                                   mem_we,
    output logic [COL_W-1:0]                       mem_waddr,
    output logic [iapr_pkg::PIXEL_W-1:0]           mem_wdata,
    input  logic [iapr_pkg::PIXEL_W-1:0]           mem_rdata,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [iapr_pkg::PIXEL_W-1:0]           pixel,
    output logic                                   frame_end
);
    import iapr_pkg::*;

    logic                  s1_valid_reg;
    logic [PIXEL_W-1:0]    res_reg;
    pos_t                  pos_reg;
    logic [COL_W-1:0]      col_s1_reg;
    logic                  byp_valid_reg;
    logic [PIXEL_W-1:0]    byp_data_reg;
    logic [PIXEL_W-1:0]    left_reg;
    logic [PIXEL_W-1:0]    ul_reg;
    logic                  out_valid_reg;
    logic [PIXEL_W-1:0]    pixel_reg;
    logic                  frame_end_reg;
    logic                  fire;
    logic [PIXEL_W-1:0]    upper;
    logic [SUM_W-1:0]      operand;
    logic [PIXEL_W-1:0]    pred;
    logic [PIXEL_W-1:0]    pix;

    assign fire     = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !fire;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        upper = byp_valid_reg ? byp_data_reg : mem_rdata;
        if (pos_reg.first_row && pos_reg.first_col)
        begin
            operand = '0;
        end
        else if (pos_reg.first_row)
        begin
            operand = SUM_W'(left_reg);
        end
        else if (pos_reg.first_col)
        begin
            operand = SUM_W'(upper);
        end
        else
        begin
            operand = SUM_W'(ul_reg) + SUM_W'(upper) + SUM_W'(left_reg);
        end
        pred = div3(operand);
        pix  = res_reg + pred;
    end

    assign mem_we    = fire;
    assign mem_waddr = col_s1_reg;
    assign mem_wdata = pix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
            ul_reg        <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
                left_reg      <= pix;
                ul_reg        <= upper;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg       <= residual[PIXEL_W-1:0];
            pos_reg       <= pos;
            col_s1_reg    <= col;
            byp_valid_reg <= fire && (col == col_s1_reg);
            byp_data_reg  <= pix;
        end
        if (fire)
        begin
            pixel_reg     <= pix;
            frame_end_reg <= pos_reg.last_col && pos_reg.last_row;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel     = pixel_reg;
    assign frame_end = frame_end_reg;

endmodule

@@ src/iapr_checker.sv @@
// Port-level checks for the intra average pixel reconstructor, bound to its top level.
// Depends on iapr_pkg for the port widths.
module iapr_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   in_valid,
    input logic                                   in_stall,
    input logic signed [iapr_pkg::RESIDUAL_W-1:0] residual,
    input logic                                   out_valid,
    input logic                                   out_stall,
    input logic [iapr_pkg::PIXEL_W-1:0]           pixel,
    input logic                                   frame_end
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(pixel) && $stable(frame_end))
        else $error("stalled result changed");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("request stalled while result side is free");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result without a request two cycles earlier");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(residual))
        else $error("stalled request changed");

endmodule

bind intra_average_pixel_reconstruct iapr_checker u_iapr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .residual  (residual),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pixel     (pixel),
    .frame_end (frame_end)
);

@@ sim/tb.sv @@
// Testbench for intra_average_pixel_reconstruct: drives signed residuals in raster order
// and checks every reconstructed pixel and frame-end flag against a predictor kept here.
// Depends on iapr_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;
    import iapr_pkg::*;

    localparam int LINE_DEPTH     = 4096;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 20;
    localparam int PHASE_COUNT    = 12;
    localparam int PHASE_REQUESTS = 150;

    typedef struct {
        logic [PIXEL_W-1:0] pixel;
        logic               frame_end;
    } pixel_result_t;

    logic                         clk;
    logic                         rst_n = 1'b0;
    logic                         cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0]       cfg_index = REG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0]        cfg_data = '0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic signed [RESIDUAL_W-1:0] residual = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [PIXEL_W-1:0]           pixel;
    logic                         frame_end;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int error_count   = 0;
    int requests_taken = 0;
    int pixels_checked = 0;
    int frames_closed  = 0;
    int size_settings  = 0;
    int quiet_cycles   = 0;

    pixel_result_t expected_pixels[$];

    logic [CFG_DATA_W-1:0] width_setting  = CFG_DATA_W'(WIDTH_RESET);
    logic [CFG_DATA_W-1:0] height_setting = CFG_DATA_W'(HEIGHT_RESET);
    logic [PIXEL_W-1:0]    line_pixels[LINE_DEPTH];
    bit                    line_written[LINE_DEPTH];
    logic [PIXEL_W-1:0]    left_value = '0;
    logic [PIXEL_W-1:0]    diag_value = '0;
    int                    cur_col = 0;
    int                    cur_row = 0;

    intra_average_pixel_reconstruct DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .residual  (residual),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel     (pixel),
        .frame_end (frame_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int effective_size(input logic [CFG_DATA_W-1:0] v);
        if (v == '0)
        begin
            return 1;
        end
        if (v > LINE_DEPTH)
        begin
            return LINE_DEPTH;
        end
        return int'(v);
    endfunction

    function automatic bit width_write_safe(input logic [CFG_DATA_W-1:0] v);
        int w;
        w = effective_size(v);
        if (cur_row == 0)
        begin
            return 1'b1;
        end
        for (int i = 0; i < w; i++)
        begin
            if (!line_written[i])
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic reconstruct_pixel(input logic signed [RESIDUAL_W-1:0] r,
                                     output pixel_result_t res);
        int w;
        int h;
        int upper;
        int guess;
        int total;
        bit last_col;
        bit last_row;
        w = effective_size(width_setting);
        h = effective_size(height_setting);
        upper = line_written[cur_col] ? int'(line_pixels[cur_col]) : 0;
        if (cur_row == 0 && cur_col == 0)
        begin
            guess = 0;
        end
        else if (cur_row == 0)
        begin
            guess = int'(left_value) / 3;
        end
        else if (cur_col == 0)
        begin
            guess = upper / 3;
        end
        else
        begin
            guess = (int'(diag_value) + upper + int'(left_value)) / 3;
        end
        total = int'(r) + guess;
        res.pixel = total[PIXEL_W-1:0];
        diag_value = upper[PIXEL_W-1:0];
        left_value = res.pixel;
        line_pixels[cur_col] = res.pixel;
        line_written[cur_col] = 1'b1;
        last_col = (cur_col + 1 >= w);
        last_row = (cur_row + 1 >= h);
        res.frame_end = last_col && last_row;
        if (last_col)
        begin
            cur_col = 0;
            cur_row = last_row ? 0 : cur_row + 1;
        end
        else
        begin
            cur_col = cur_col + 1;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin : scoreboard
        pixel_result_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                reconstruct_pixel(residual, want);
                expected_pixels.push_back(want);
                requests_taken++;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    report_mismatch("pixel with no request pending", int'(pixel), -1);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    pixels_checked++;
                    if (want.frame_end)
                    begin
                        frames_closed++;
                    end
                    if (pixel !== want.pixel)
                    begin
                        report_mismatch("pixel", int'(pixel), int'(want.pixel));
                    end
                    if (frame_end !== want.frame_end)
                    begin
                        report_mismatch("frame_end", int'(frame_end), int'(want.frame_end));
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_residual(input logic signed [RESIDUAL_W-1:0] r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        residual <= r;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_pixels.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_frame_size(input logic [CFG_DATA_W-1:0] w,
                                  input logic [CFG_DATA_W-1:0] h,
                                  input bit write_w, input bit write_h);
        if (write_w)
        begin
            cfg_write <= 1'b1;
            cfg_index <= REG_FRAME_WIDTH;
            cfg_data  <= w;
            @(posedge clk);
            width_setting = w;
        end
        if (write_h)
        begin
            cfg_write <= 1'b1;
            cfg_index <= REG_FRAME_HEIGHT;
            cfg_data  <= h;
            @(posedge clk);
            height_setting = h;
        end
        cfg_write <= 1'b0;
        size_settings++;
    endtask

    function automatic logic signed [RESIDUAL_W-1:0] random_residual();
        if ($urandom_range(9) < 7)
        begin
            return RESIDUAL_W'($urandom_range(511));
        end
        return RESIDUAL_W'(int'($urandom_range(8)) - 4);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_size();
        case ($urandom_range(9))
            0:       return '0;
            1:       return CFG_DATA_W'(1);
            2:       return CFG_DATA_W'($urandom_range(8191, LINE_DEPTH + 1));
            3:       return CFG_DATA_W'($urandom_range(64, 2));
            default: return CFG_DATA_W'($urandom_range(12, 1));
        endcase
    endfunction

    task automatic test_edge_residuals();
        send_residual(9'sd255);
        send_residual(-9'sd255);
        send_residual(9'h100);
        send_residual(9'sd0);
        wait_drained();
        // shrink width in the middle of row zero: the row ends on the next request
        set_frame_size(13'd3, 13'd2, 1'b1, 1'b1);
        send_residual(9'sd1);
        send_residual(-9'sd1);
        send_residual(9'sd127);
        send_residual(-9'sd128);
        send_residual(9'sd255);
        send_residual(9'sd1);
        send_residual(-9'sd255);
        send_residual(9'sd0);
        send_residual(9'sd255);
        send_residual(9'sd255);
        send_residual(9'sd255);
        wait_drained();
        set_frame_size(13'd0, 13'd0, 1'b1, 1'b1);
        send_residual(9'sd255);
        send_residual(9'h100);
        send_residual(9'sd5);
        wait_drained();
        set_frame_size(13'd1, 13'd3, 1'b1, 1'b1);
        send_residual(9'sd200);
        send_residual(-9'sd50);
        send_residual(9'sd100);
        send_residual(9'h0FF);
        wait_drained();
    endtask

    task automatic test_size_limits();
        send_idle_pct = 32;
        stall_pct = 32;
        // start a fresh frame so row zero covers the widened line
        while (cur_col != 0 || cur_row != 0)
        begin
            send_residual(random_residual());
            wait_drained();
        end
        wait_drained();
        set_frame_size(13'd8191, 13'd8191, 1'b1, 1'b1);
        repeat (30) send_residual(random_residual());
        wait_drained();
        set_frame_size(13'd4096, 13'd4096, 1'b1, 1'b1);
        repeat (10) send_residual(random_residual());
        wait_drained();
        set_frame_size(13'd6, 13'd4096, 1'b1, 1'b0);
        repeat (25) send_residual(random_residual());
        wait_drained();
        set_frame_size(13'd6, 13'd2, 1'b0, 1'b1);
        repeat (20) send_residual(random_residual());
        wait_drained();
    endtask

    task automatic test_random_frames();
        logic [CFG_DATA_W-1:0] w;
        logic [CFG_DATA_W-1:0] h;
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 82;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 82;
                end
                default:
                begin
                    send_idle_pct = 32;
                    stall_pct = 32;
                end
            endcase
            w = random_size();
            h = random_size();
            set_frame_size(w, h, width_write_safe(w), 1'b1);
            for (int n = 0; n < PHASE_REQUESTS; n++)
            begin
                if (phase == 5 && n == PHASE_REQUESTS / 2)
                begin
                    wait_drained();
                end
                send_residual(random_residual());
            end
            wait_drained();
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_edge_residuals();
        test_size_limits();
        test_random_frames();
        wait_drained();
        stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Run covered %0d residuals and %0d checked pixels over %0d frame ends,",
                 requests_taken, pixels_checked, frames_closed);
        $display("with %0d frame size settings and mismatches: %0d.",
                 size_settings, error_count);
        if (error_count == 0 && expected_pixels.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
